/* src/bba_pkg.sv */
// ============================================================================
// bba_pkg
// Shared types, constants and search helper of the bitmap block allocator.
// ============================================================================
package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int BIT_AW     = $clog2(WORD_W);

    localparam int GRP_W      = 8;
    localparam int NUM_GRP    = WORD_W / GRP_W;
    localparam int GRP_AW     = $clog2(NUM_GRP);
    localparam int SUB_AW     = $clog2(GRP_W);

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL_B  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_SPACE = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_TOTAL    = 1'b0,
        REG_RESERVED = 1'b1
    } t_reg_sel;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_FORMAT,
        CMD_REJECT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FORMAT,
        S_ALLOC,
        S_FREE
    } t_eng_state;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] idx;
    } t_find;

    // lowest set bit, byte group first then bit within the group
    function automatic t_find find_first(input logic [WORD_W-1:0] v);
        t_find             f;
        logic [NUM_GRP-1:0] any;
        logic [GRP_AW-1:0] g;
        logic [SUB_AW-1:0] b;
        logic [GRP_W-1:0]  sel;
        g = '0;
        b = '0;
        for (int i = 0; i < NUM_GRP; i++) begin
            any[i] = |v[i*GRP_W +: GRP_W];
        end
        for (int i = NUM_GRP - 1; i >= 0; i--) begin
            if (any[i]) begin
                g = GRP_AW'(i);
            end
        end
        sel = v[{g, SUB_AW'(0)} +: GRP_W];
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (sel[i]) begin
                b = SUB_AW'(i);
            end
        end
        f.found = |any;
        f.idx   = {g, b};
        return f;
    endfunction

endpackage

/* src/bba_if.sv */
// ============================================================================
// bba request and response channels
// Valid/ready channels carrying allocator operations and their results.
// ============================================================================
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::OP_W-1:0]   opcode;
    logic [bba_pkg::IDX_W-1:0]  block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::IDX_W-1:0]    granted_index;
    logic [bba_pkg::CNT_W-1:0]    free_count;

    modport source (output valid, output status, output granted_index, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_index, input free_count,
                    output ready);
endinterface

/* src/bba_front.sv */
// ============================================================================
// bba_front
// Accepts operations and classifies them into commands for the queue.
// ============================================================================
module bba_front (
    bba_req_if.sink                 i_req,
    input  logic [bba_pkg::CNT_W-1:0] i_total_eff,
    input  logic                    i_full,
    output logic                    o_push,
    output bba_pkg::t_cmd           o_cmd
);
    import bba_pkg::*;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd.idx = i_req.block_index;
        unique case (i_req.opcode)
            OP_ALLOC:  o_cmd.kind = CMD_ALLOC;
            OP_FORMAT: o_cmd.kind = CMD_FORMAT;
            OP_FREE: begin
                // out-of-range free is rejected up front
                if ({1'b0, i_req.block_index} < i_total_eff) begin
                    o_cmd.kind = CMD_FREE;
                end else begin
                    o_cmd.kind = CMD_REJECT;
                end
            end
            default:   o_cmd.kind = CMD_REJECT;
        endcase
    end

endmodule

/* src/bba_cmd_fifo.sv */
// ============================================================================
// bba_cmd_fifo
// Small command queue decoupling the front end from the map engine.
// ============================================================================
module bba_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bba_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bba_pkg::t_cmd o_cmd
);
    import bba_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

/* src/bba_engine.sv */
// ============================================================================
// bba_engine
// Usage map, non-full word summary and free counter; executes commands.
// ============================================================================
module bba_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  bba_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    input  logic [bba_pkg::CNT_W-1:0] i_total_eff,
    input  logic [bba_pkg::CNT_W-1:0] i_res_eff,
    bba_rsp_if.source                 o_rsp
);
    import bba_pkg::*;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    logic [WORD_W-1:0]    r_map [NUM_WORDS];
    logic [WORD_W-1:0]    r_rdata;

    t_eng_state           r_state, n_state;
    logic [WORD_AW-1:0]   r_word, n_word;
    logic [BIT_AW-1:0]    r_bit, n_bit;
    logic [CNT_W-1:0]     r_fcnt, n_fcnt;
    logic                 r_formatted, n_formatted;
    logic [NUM_WORDS-1:0] r_full, n_full;
    logic                 r_out_valid, n_out_valid;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_granted, n_granted;
    logic [CNT_W-1:0]     r_ocnt, n_ocnt;

    logic [WORD_AW-1:0]   rd_addr;
    logic                 map_we;
    logic [WORD_W-1:0]    map_wd;

    t_find                word_find;
    t_find                bit_find;
    logic [CNT_W-1:0]     word_base;
    logic [CNT_W-1:0]     res_diff;
    logic [WORD_W-1:0]    fmt_pat;
    logic [IDX_W-1:0]     grant_idx;
    logic [CNT_W-1:0]     fcnt_dec;
    logic [CNT_W-1:0]     fcnt_inc;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.free_count    = r_ocnt;

    assign word_find = find_first(~r_full);
    assign bit_find  = find_first(~r_rdata);
    assign grant_idx = {r_word, bit_find.idx};
    assign fcnt_dec  = (r_fcnt != '0) ? r_fcnt - 1'b1 : r_fcnt;
    assign fcnt_inc  = (r_fcnt < i_total_eff) ? r_fcnt + 1'b1 : r_fcnt;

    // reserved pattern of the word being formatted
    always_comb begin
        word_base = {1'b0, r_word, BIT_AW'(0)};
        res_diff  = i_res_eff - word_base;
        if (i_res_eff <= word_base) begin
            fmt_pat = '0;
        end else if (res_diff >= CNT_W'(WORD_W)) begin
            fmt_pat = '1;
        end else begin
            fmt_pat = ~({WORD_W{1'b1}} << res_diff[BIT_AW-1:0]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_bit       = r_bit;
        n_fcnt      = r_fcnt;
        n_formatted = r_formatted;
        n_full      = r_full;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_granted   = r_granted;
        n_ocnt      = r_ocnt;
        o_pop       = 1'b0;
        rd_addr     = r_word;
        map_we      = 1'b0;
        map_wd      = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (!r_out_valid && !i_empty) begin
                    o_pop     = 1'b1;
                    n_status  = ST_INVALID;
                    n_granted = '0;
                    n_ocnt    = r_fcnt;
                    unique case (i_cmd.kind)
                        CMD_FORMAT: begin
                            n_word  = '0;
                            n_state = S_FORMAT;
                        end
                        CMD_ALLOC: begin
                            if (!r_formatted) begin
                                n_out_valid = 1'b1;
                            end else if (!word_find.found) begin
                                n_status    = ST_NO_SPACE;
                                n_out_valid = 1'b1;
                            end else begin
                                n_word  = word_find.idx;
                                rd_addr = word_find.idx;
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            if (!r_formatted) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_word  = i_cmd.idx[IDX_W-1:BIT_AW];
                                n_bit   = i_cmd.idx[BIT_AW-1:0];
                                rd_addr = i_cmd.idx[IDX_W-1:BIT_AW];
                                n_state = S_FREE;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FORMAT: begin
                map_we         = 1'b1;
                map_wd         = fmt_pat;
                n_full[r_word] = &fmt_pat;
                n_word         = r_word + 1'b1;
                if (r_word == LAST_WORD) begin
                    n_formatted = 1'b1;
                    n_fcnt      = i_total_eff - i_res_eff;
                    n_status    = ST_OK;
                    n_ocnt      = i_total_eff - i_res_eff;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ALLOC: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                if (!bit_find.found || ({1'b0, grant_idx} >= i_total_eff)) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    map_we         = 1'b1;
                    map_wd         = r_rdata | (WORD_W'(1) << bit_find.idx);
                    n_full[r_word] = &map_wd;
                    n_fcnt         = fcnt_dec;
                    n_status       = ST_OK;
                    n_granted      = grant_idx;
                    n_ocnt         = fcnt_dec;
                end
            end
            S_FREE: begin
                map_we         = 1'b1;
                map_wd         = r_rdata & ~(WORD_W'(1) << r_bit);
                n_full[r_word] = 1'b0;
                n_fcnt         = fcnt_inc;
                n_status       = ST_OK;
                n_ocnt         = fcnt_inc;
                n_out_valid    = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fcnt      <= '0;
            r_formatted <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fcnt      <= n_fcnt;
            r_formatted <= n_formatted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_bit     <= n_bit;
        r_full    <= n_full;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_ocnt    <= n_ocnt;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[r_word] <= map_wd;
        end
        r_rdata <= r_map[rd_addr];
    end

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && !r_out_valid))
        else $error("command taken while engine busy");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending during map operation");

    a_grant_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_granted != '0) |-> (r_status == ST_OK))
        else $error("nonzero grant without success");

    a_format_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FORMAT && r_word == LAST_WORD) |=> (r_formatted && r_out_valid))
        else $error("format sweep did not complete");

endmodule

/* src/bitmap_block_allocator_unit.sv */
// ============================================================================
// bitmap_block_allocator_unit
// First-fit block allocator over a usage bitmap with a free block counter.
// ============================================================================
// The map is held as 64-bit words in a single-port memory with a per-word
// "full" summary in flops. Allocate finds the first non-full word from the
// summary, reads it and sets its lowest clear bit. Free is a read-modify-write
// of one word. Format sweeps all 64 words, one per cycle. Operations answered
// without touching the map (invalid, or no space seen from the summary) are
// answered straight from the idle state. Results sit in an output register,
// and a two-entry command queue keeps taking requests, while it has room, as
// the engine works or a result waits; the engine takes the next command only
// once the result has been transferred, so an allocate or free passes through
// the map read, the update and the result register, and response stalls hold
// back the next command. No clearing pass follows reset: allocate and free
// answer invalid until the first format.
module bitmap_block_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bba_req_if.sink                     i_req,
    bba_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bba_pkg::PADDR_W-1:0] paddr,
    input  logic [bba_pkg::PDATA_W-1:0] pwdata,
    output logic [bba_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bba_pkg::*;

    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_reserved;
    logic [CNT_W-1:0] total_eff;
    logic [CNT_W-1:0] res_eff;
    t_reg_sel         reg_sel;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_cmd             q_in;
    t_cmd             q_out;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_sel'(paddr[REG_SEL_B]);

    always_comb begin
        unique case (reg_sel)
            REG_TOTAL:    prdata = PDATA_W'(r_total);
            REG_RESERVED: prdata = PDATA_W'(r_reserved);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= CNT_W'(MAX_BLOCKS);
            r_reserved <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_TOTAL:    r_total    <= pwdata[CNT_W-1:0];
                REG_RESERVED: r_reserved <= pwdata[CNT_W-1:0];
                default:      r_total    <= r_total;
            endcase
        end
    end

    // totals clamp to the map size, reserved to the total
    assign total_eff = (r_total > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_total;
    assign res_eff   = (r_reserved < total_eff) ? r_reserved : total_eff;

    bba_front u_front (
        .i_req       (i_req),
        .i_total_eff (total_eff),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    bba_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    bba_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (q_out),
        .o_pop       (q_pop),
        .i_total_eff (total_eff),
        .i_res_eff   (res_eff),
        .o_rsp       (o_rsp)
    );

endmodule

/* bench/bba_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// bba_checker
// Watches the request, response and register channels of the allocator.
// Keeps its own usage map, free counter and register copies, works out the
// result of every accepted operation and compares each response against the
// oldest outstanding one. Register reads are checked against the copies.
// ============================================================================
module bba_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bba_req_if                          req,
    bba_rsp_if                          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bba_pkg::PADDR_W-1:0] paddr,
    input  logic [bba_pkg::PDATA_W-1:0] pwdata,
    input  logic [bba_pkg::PDATA_W-1:0] prdata,
    input  logic                        pready,
    output int                          o_fails,
    output int                          o_pending
);
    import bba_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted;
        logic [CNT_W-1:0]    free_count;
    } t_alloc_result;

    logic [MAX_BLOCKS-1:0] block_used;
    logic [CNT_W-1:0]      spare_count;
    logic                  armed;
    logic [CNT_W-1:0]      total_reg;
    logic [CNT_W-1:0]      reserved_reg;
    t_alloc_result         result_q[$];

    function automatic t_alloc_result apply_op(input logic [OP_W-1:0] op,
                                               input logic [IDX_W-1:0] idx);
        t_alloc_result r;
        int            lim;
        int            res;
        bit            hit;
        lim       = (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_reg);
        r.status  = ST_INVALID;
        r.granted = '0;
        hit       = 1'b0;
        case (op)
            OP_FORMAT: begin
                res        = (int'(reserved_reg) < lim) ? int'(reserved_reg) : lim;
                block_used = '0;
                for (int i = 0; i < res; i++) begin
                    block_used[i] = 1'b1;
                end
                spare_count = CNT_W'(lim - res);
                armed       = 1'b1;
                r.status    = ST_OK;
            end
            OP_ALLOC: begin
                if (armed) begin
                    r.status = ST_NO_SPACE;
                    for (int i = 0; i < lim; i++) begin
                        if (!hit && !block_used[i]) begin
                            hit           = 1'b1;
                            block_used[i] = 1'b1;
                            if (spare_count > 0) begin
                                spare_count = spare_count - 1'b1;
                            end
                            r.granted = IDX_W'(i);
                            r.status  = ST_OK;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (armed && int'(idx) < lim) begin
                    block_used[idx] = 1'b0;
                    if (int'(spare_count) < lim) begin
                        spare_count = spare_count + 1'b1;
                    end
                    r.status = ST_OK;
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        r.free_count = spare_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result want;
        logic [CNT_W-1:0] reg_val;
        if (!i_rst_n) begin
            block_used   = '0;
            spare_count  = '0;
            armed        = 1'b0;
            total_reg    = CNT_W'(MAX_BLOCKS);
            reserved_reg = '0;
            o_fails      = 0;
            result_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (t_reg_sel'(paddr[REG_SEL_B]) == REG_RESERVED) begin
                        reserved_reg = pwdata[CNT_W-1:0];
                    end else begin
                        total_reg = pwdata[CNT_W-1:0];
                    end
                end else begin
                    reg_val = (t_reg_sel'(paddr[REG_SEL_B]) == REG_RESERVED) ?
                              reserved_reg : total_reg;
                    if (prdata !== PDATA_W'(reg_val)) begin
                        $error("prdata expected %0d actual %0d", reg_val, prdata);
                        o_fails++;
                    end
                end
            end
            // response first: a transfer in the same cycle belongs to an older op
            if (rsp.valid && rsp.ready) begin
                if (result_q.size() == 0) begin
                    $error("response transfer with no operation outstanding");
                    o_fails++;
                end else begin
                    want = result_q.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        o_fails++;
                    end
                    if (rsp.granted_index !== want.granted) begin
                        $error("granted_index expected %0d actual %0d",
                               want.granted, rsp.granted_index);
                        o_fails++;
                    end
                    if (rsp.free_count !== want.free_count) begin
                        $error("free_count expected %0d actual %0d",
                               want.free_count, rsp.free_count);
                        o_fails++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                result_q.push_back(apply_op(req.opcode, req.block_index));
            end
        end
        o_pending = result_q.size();
    end

endmodule

/* bench/bitmap_block_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// bitmap_block_allocator_unit_tb
// Drives allocate, free and format operations and register settings into the
// allocator: a directed opening over the corner cases, then random phases
// with mostly small block totals so the map fills and drains. The checker
// beside the block predicts and compares; this module gives the verdict.
// ============================================================================
module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNDEF   = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_TOTAL = PADDR_W'(REG_TOTAL) << 2;
    localparam logic [PADDR_W-1:0] ADDR_RSV   = PADDR_W'(REG_RESERVED) << 2;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int STALL_LIMIT   = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fails;
    int                 pending;
    int                 sent_count;
    int                 stall_cycles;
    logic               quiet;

    bba_req_if req_ch();
    bba_rsp_if rsp_ch();

    bitmap_block_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bba_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready = quiet || ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        while (!quiet && $urandom_range(99) < 7) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.opcode      = op;
        req_ch.block_index = idx;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [CNT_W-1:0] total, input logic [CNT_W-1:0] rsv);
        wait_idle();
        apb_access(1'b1, ADDR_TOTAL, PDATA_W'(total));
        apb_access(1'b0, ADDR_TOTAL, '0);
        apb_access(1'b1, ADDR_RSV, PDATA_W'(rsv));
        apb_access(1'b0, ADDR_RSV, '0);
    endtask

    initial begin
        int               lim;
        int               pick;
        int               n_items;
        int               tot;
        int               rsv;
        logic [IDX_W-1:0] idx;
        i_rst_n            = 1'b0;
        quiet              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_ALLOC;
        req_ch.block_index = '0;
        sent_count         = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // before and after a first format, on reset register values
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, '0);
        send_op(OP_UNDEF, '1);
        send_op(OP_FORMAT, '0);
        send_op(OP_ALLOC, '1);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, '1);
        send_op(OP_FREE, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_UNDEF, '0);

        // small map with reserved blocks, run out of space, free out of range
        set_config(13'd8, 13'd3);
        send_op(OP_FORMAT, '0);
        repeat (6) send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 12'd7);
        send_op(OP_FREE, 12'd8);
        send_op(OP_FREE, '1);

        // zero total
        set_config('0, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, '0);
        send_op(OP_FORMAT, '0);

        // total above the maximum, everything reserved
        set_config('1, '1);
        send_op(OP_FORMAT, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, '1);
        send_op(OP_ALLOC, '0);

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 55) tot = $urandom_range(64, 1);
            else if (pick < 75) tot = $urandom_range(600, 65);
            else if (pick < 82) tot = MAX_BLOCKS;
            else if (pick < 86) tot = 0;
            else if (pick < 90) tot = $urandom_range(8191, MAX_BLOCKS + 1);
            else tot = $urandom_range(MAX_BLOCKS - 1, 601);
            lim  = (tot > MAX_BLOCKS) ? MAX_BLOCKS : tot;
            pick = $urandom_range(99);
            if (pick < 60) rsv = $urandom_range(lim / 2, 0);
            else if (pick < 75) rsv = 0;
            else if (pick < 85) rsv = (lim + 5 > 8191) ? 8191 : $urandom_range(lim + 5, lim);
            else if (pick < 92) rsv = 8191;
            else rsv = $urandom_range(8191, 0);
            set_config(CNT_W'(tot), CNT_W'(rsv));
            quiet = (sent_count >= 500 && sent_count < 800);
            // some phases keep the old map to see the new total act at once
            if ($urandom_range(3) != 0) begin
                send_op(OP_FORMAT, IDX_W'($urandom));
            end
            n_items = $urandom_range(60, 15);
            repeat (n_items) begin
                pick = $urandom_range(99);
                idx  = IDX_W'($urandom);
                if (pick < 48) begin
                    send_op(OP_ALLOC, idx);
                end else if (pick < 83) begin
                    if (lim > 0 && $urandom_range(99) < 85) begin
                        idx = IDX_W'($urandom_range(lim - 1, 0));
                    end
                    send_op(OP_FREE, idx);
                end else if (pick < 90) begin
                    send_op(OP_FORMAT, idx);
                end else if (pick < 95) begin
                    send_op(OP_UNDEF, idx);
                end else begin
                    send_op(OP_FREE, IDX_W'(lim));
                end
            end
        end
        quiet = 1'b0;

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
